// ----- hdl/dsa_pkg.sv -----
// Package for the descriptor slot allocator: pool size, field widths,
// status and mode codes, payload structs, the slot store write bundle and read entry.
// No dependencies; every other file of the block imports it.
package dsa_pkg;

  // Pool size and the widths that follow from it.
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Fixed field widths of the transfer payloads.
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 8;
  localparam int STAT_W  = 2;
  localparam int OSLOT_W = 6;
  localparam int FREED_W = 7;

  localparam logic [INDEX_W-1:0] SLOT_LIMIT = INDEX_W'(SLOT_COUNT);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC_ONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC_THREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE_ONE      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CHAIN_RELEASE = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE        = 2'd2;
  localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] slot_index;
  } dsa_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [OSLOT_W-1:0] first_slot;
    logic [OSLOT_W-1:0] second_slot;
    logic [OSLOT_W-1:0] third_slot;
    logic [FREED_W-1:0] freed_count;
  } dsa_out_t;

  // Write requests from the sequencer to the slot store.
  typedef struct packed {
    logic                  clr_en;
    logic [SLOT_COUNT-1:0] clr_mask;
    logic                  link_en;
    logic [SLOT_W-1:0]     link_slot;
    logic [SLOT_W-1:0]     link_val;
    logic                  link_has;
    logic                  rel_en;
    logic [SLOT_W-1:0]     rel_slot;
  } dsa_wr_t;

  // One entry of the slot store as seen by the chain walk.
  typedef struct packed {
    logic              free;
    logic              has_next;
    logic [SLOT_W-1:0] next;
  } dsa_rd_t;

endpackage

// ----- hdl/dsa_lowest_free.sv -----
// Shared priority search: finds the lowest set bit of a slot map.
// Depends on dsa_pkg for the pool size.
module dsa_lowest_free import dsa_pkg::*; (
  input  logic [SLOT_COUNT-1:0] map_i,
  output logic                  found_o,
  output logic [SLOT_W-1:0]     slot_o
);

  always_comb begin
    found_o = 1'b0;
    slot_o  = '0;
    // Scan downward so the lowest set bit wins.
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (map_i[i]) begin
        found_o = 1'b1;
        slot_o  = SLOT_W'(i);
      end
    end
  end

endmodule

// ----- hdl/dsa_slot_store.sv -----
// Slot store: free map, next links and has-next marks of every slot,
// with one read port for the chain walk. Depends on dsa_pkg.
module dsa_slot_store import dsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsa_wr_t               wr_i,
  input  logic [SLOT_W-1:0]     rd_slot_i,
  output dsa_rd_t               rd_o,
  output logic [SLOT_COUNT-1:0] free_map_o
);

  logic [SLOT_COUNT-1:0] free_q;
  logic [SLOT_COUNT-1:0] has_q;
  logic [SLOT_W-1:0]     link_q [SLOT_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      has_q  <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        link_q[i] <= '0;
      end
    end else begin
      if (wr_i.clr_en) begin
        free_q <= free_q & ~wr_i.clr_mask;
      end
      if (wr_i.link_en) begin
        link_q[wr_i.link_slot] <= wr_i.link_val;
        has_q[wr_i.link_slot]  <= wr_i.link_has;
      end
      // A released slot always returns with its link cleared.
      if (wr_i.rel_en) begin
        free_q[wr_i.rel_slot] <= 1'b1;
        link_q[wr_i.rel_slot] <= '0;
        has_q[wr_i.rel_slot]  <= 1'b0;
      end
    end
  end

  assign rd_o.free     = free_q[rd_slot_i];
  assign rd_o.has_next = has_q[rd_slot_i];
  assign rd_o.next     = link_q[rd_slot_i];
  assign free_map_o    = free_q;

endmodule

// ----- hdl/descriptor_slot_allocator.sv -----
// Steps per input transfer: alloc_one runs a search pass and a finish step; free_one releases one
// slot, then finishes; alloc_three runs three search passes, a link step and a finish step, or goes
// to finish when a pass finds no free slot; chain release walks its slots, then finishes. The finish
// step loads the result once the output register can take it. One item at a time; the next item is
// accepted once the sequencer is back in idle, after the result is loaded. A result waiting in the
// output register does not block acceptance. Reset (async, active low) frees every slot, clears links.
module descriptor_slot_allocator import dsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dsa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dsa_out_t out_data_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [SLOT_COUNT-1:0] ONE_HOT0 = SLOT_COUNT'(1);

  logic [2:0]            state_q, state_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [1:0]            step_q, step_d;
  logic [SLOT_COUNT-1:0] work_q, work_d;
  logic [SLOT_W-1:0]     slot0_q, slot0_d;
  logic [SLOT_W-1:0]     slot1_q, slot1_d;
  logic [SLOT_W-1:0]     slot2_q, slot2_d;
  logic [INDEX_W-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [STAT_W-1:0]     status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  dsa_out_t              out_q, out_d;

  logic                  in_fire;
  logic                  out_load;
  dsa_wr_t               wr;
  dsa_rd_t               rd;
  logic [SLOT_COUNT-1:0] free_map;
  logic                  found;
  logic [SLOT_W-1:0]     found_slot;
  logic [SLOT_COUNT-1:0] found_hot;
  logic                  alloc_ok;

  // The shared search unit always looks at the working copy of the free map.
  // Each successful pass removes its slot from that copy, so the next pass finds
  // the next lowest free slot.
  dsa_lowest_free u_search (
    .map_i   (work_q),
    .found_o (found),
    .slot_o  (found_slot)
  );

  dsa_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_slot_i  (cur_q[SLOT_W-1:0]),
    .rd_o       (rd),
    .free_map_o (free_map)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign found_hot  = ONE_HOT0 << found_slot;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    step_d   = step_q;
    work_d   = work_q;
    slot0_d  = slot0_q;
    slot1_d  = slot1_q;
    slot2_d  = slot2_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    out_load = 1'b0;
    wr       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d   = in_data_i.mode;
          cur_d    = in_data_i.slot_index;
          step_d   = 2'd0;
          cnt_d    = '0;
          status_d = ST_OK;
          work_d   = free_map;
          if (in_data_i.mode == MODE_ALLOC_ONE || in_data_i.mode == MODE_ALLOC_THREE) begin
            state_d = S_SRCH;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_SRCH: begin
        // Nothing is committed until every slot the request needs has been found,
        // so a failing request leaves the pool untouched.
        if (!found) begin
          status_d = ST_NO_SPACE;
          state_d  = S_FIN;
        end else begin
          work_d = work_q & ~found_hot;
          unique case (step_q)
            2'd0: begin
              slot0_d = found_slot;
              if (mode_q == MODE_ALLOC_ONE) begin
                // A single allocation leaves the slot's link alone.
                wr.clr_en   = 1'b1;
                wr.clr_mask = found_hot;
                state_d     = S_FIN;
              end else begin
                step_d = 2'd1;
              end
            end
            2'd1: begin
              slot1_d = found_slot;
              step_d  = 2'd2;
            end
            default: begin
              slot2_d      = found_slot;
              wr.clr_en    = 1'b1;
              wr.clr_mask  = (ONE_HOT0 << slot0_q) | (ONE_HOT0 << slot1_q) | found_hot;
              wr.link_en   = 1'b1;
              wr.link_slot = slot0_q;
              wr.link_val  = slot1_q;
              wr.link_has  = 1'b1;
              state_d      = S_LINK;
            end
          endcase
        end
      end

      S_LINK: begin
        // The tail slot was free, so its link is already clear.
        wr.link_en   = 1'b1;
        wr.link_slot = slot1_q;
        wr.link_val  = slot2_q;
        wr.link_has  = 1'b1;
        state_d      = S_FIN;
      end

      S_WALK: begin
        // One slot per cycle. A single free is a walk that stops after one slot.
        // A cyclic chain ends here too, at a slot freed earlier in the walk.
        if (cur_q >= SLOT_LIMIT) begin
          status_d = ST_RANGE;
          state_d  = S_FIN;
        end else if (rd.free) begin
          status_d = ST_ALREADY_FREE;
          state_d  = S_FIN;
        end else begin
          wr.rel_en   = 1'b1;
          wr.rel_slot = cur_q[SLOT_W-1:0];
          cnt_d       = CNT_W'(cnt_q + 1'b1);
          if (mode_q == MODE_FREE_ONE || !rd.has_next) begin
            state_d = S_FIN;
          end else begin
            cur_d = INDEX_W'(rd.next);
          end
        end
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result assembly: slot fields are zero unless an allocation succeeded.
  assign alloc_ok = (status_q == ST_OK) &&
                    (mode_q == MODE_ALLOC_ONE || mode_q == MODE_ALLOC_THREE);

  always_comb begin
    out_d.status      = status_q;
    out_d.first_slot  = alloc_ok ? OSLOT_W'(slot0_q) : '0;
    out_d.second_slot = (alloc_ok && mode_q == MODE_ALLOC_THREE) ? OSLOT_W'(slot1_q) : '0;
    out_d.third_slot  = (alloc_ok && mode_q == MODE_ALLOC_THREE) ? OSLOT_W'(slot2_q) : '0;
    out_d.freed_count = FREED_W'(cnt_q);
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the sequencer and the output payload.
  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    step_q   <= step_d;
    work_q   <= work_d;
    slot0_q  <= slot0_d;
    slot1_q  <= slot1_d;
    slot2_q  <= slot2_d;
    cur_q    <= cur_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A walk only ever releases a slot that is currently taken.
  a_release_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.rel_en |-> !free_map[wr.rel_slot])
    else $error("released a slot that was already free");

  // Allocation only claims slots that are currently free.
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.clr_en |-> ((wr.clr_mask & ~free_map) == '0))
    else $error("claimed a slot that was not free");

  // A triple allocation claims exactly three distinct slots.
  a_triple_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.clr_en && mode_q == MODE_ALLOC_THREE) |-> ($countones(wr.clr_mask) == 3))
    else $error("triple allocation did not claim three slots");

  // An accepted item always moves the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a transfer");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

endmodule
